### src/hcfp_pkg.sv
// Shared constants and types for the hand command frame parser.
package hcfp_pkg;

    localparam int DEF_MAX_PAYLOAD = 32;
    localparam int QUEUE_DEPTH     = 4;
    localparam int GROUP_BYTES     = 4;

    localparam logic [7:0] HEADER_BYTE     = 8'd36;
    localparam logic [7:0] END_BYTE        = 8'd33;
    localparam logic [7:0] POSITION_ACTION = 8'd3;
    localparam logic [3:0] MAX_RESULTS     = 4'd8;

    localparam logic [2:0] KIND_DRIVE = 3'd0;
    localparam logic [2:0] KIND_POS   = 3'd1;
    localparam logic [2:0] KIND_CW    = 3'd2;
    localparam logic [2:0] KIND_ACW   = 3'd3;
    localparam logic [2:0] KIND_NOP   = 3'd4;

    localparam logic [1:0] CFG_FINGER_LIMIT = 2'd0;
    localparam logic [1:0] CFG_WRIST_CW     = 2'd1;
    localparam logic [1:0] CFG_WRIST_ACW    = 2'd2;

    localparam logic [7:0] RST_FINGER_LIMIT = 8'd6;
    localparam logic [7:0] RST_WRIST_CW     = 8'd0;
    localparam logic [7:0] RST_WRIST_ACW    = 8'd1;

    typedef struct packed {
        logic [7:0] finger_limit;
        logic [7:0] wrist_cw_code;
        logic [7:0] wrist_acw_code;
    } hcfp_cfg_t;

    // commit = 0: store data at payload offset addr
    // commit = 1: emit data[3:0] groups from the stored payload
    typedef struct packed {
        logic       commit;
        logic [7:0] data;
        logic [7:0] addr;
    } hcfp_op_t;

endpackage

### src/hcfp_front.sv
// Byte parser: frame sync, payload offsets and frame check, emits store/commit ops.
module hcfp_front import hcfp_pkg::*; #(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       q_full,
    output logic       q_push,
    output hcfp_op_t   q_op
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic [1:0] phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] cnt_inc;
    logic [3:0] groups;

    assign s_ready = !q_full;
    assign cnt_inc = cnt_reg + 8'd1;
    assign groups  = (len_reg[7:2] > 6'(MAX_RESULTS)) ? MAX_RESULTS : len_reg[5:2];

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        q_push     = 1'b0;
        q_op       = '0;
        if (s_valid && s_ready) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (s_rx_byte == HEADER_BYTE) begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    len_next   = s_rx_byte;
                    cnt_next   = 8'd0;
                    phase_next = (s_rx_byte == 8'd0) ? PH_END : PH_DATA;
                end
                PH_DATA: begin
                    if (cnt_reg < MAX_LEN) begin
                        q_push      = 1'b1;
                        q_op.commit = 1'b0;
                        q_op.data   = s_rx_byte;
                        q_op.addr   = cnt_reg;
                    end
                    cnt_next = cnt_inc;
                    if (cnt_inc >= len_reg) begin
                        phase_next = PH_END;
                    end
                end
                PH_END: begin
                    phase_next = PH_HUNT;
                    if (s_rx_byte == END_BYTE && len_reg <= MAX_LEN && groups != 4'd0) begin
                        q_push      = 1'b1;
                        q_op.commit = 1'b1;
                        q_op.data   = {4'd0, groups};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            len_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### src/hcfp_fifo.sv
// Short op queue between parser and command engine.
module hcfp_fifo import hcfp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  hcfp_op_t push_op,
    output logic     full,
    input  logic     pop,
    output logic     pop_valid,
    output hcfp_op_t pop_op
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    hcfp_op_t      entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          do_push, do_pop;

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_op    = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

endmodule

### src/hcfp_back.sv
// Command engine: payload memory, group readout, decode and output register.
module hcfp_back import hcfp_pkg::*; #(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  hcfp_cfg_t   cfg,
    input  logic        op_valid,
    input  hcfp_op_t    op,
    output logic        op_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_target_id,
    output logic [2:0]  m_command_kind,
    output logic [7:0]  m_direction,
    output logic [15:0] m_command_value,
    output logic        m_last_command
);

    localparam int ROWS = (MAX_PAYLOAD + GROUP_BYTES - 1) / GROUP_BYTES;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [7:0]    mem_lane [GROUP_BYTES][ROWS];
    logic [7:0]    rdata_reg [GROUP_BYTES];

    logic [1:0]    st_reg, st_next;
    logic [3:0]    grp_reg, grp_next;
    logic [3:0]    total_reg, total_next;
    logic          m_valid_reg, m_valid_next;
    logic          out_free, load, last, wr_en;
    logic [RW-1:0] wr_row, rd_row;
    logic [1:0]    wr_lane;
    logic [2:0]    kind;
    logic [7:0]    id_reg, act_reg;
    logic [15:0]   val_reg;
    logic          last_reg;

    assign op_ready = (st_reg == ST_IDLE);
    assign wr_en    = op_valid && op_ready && !op.commit;
    assign wr_lane  = op.addr[1:0];
    assign wr_row   = RW'(op.addr[7:2]);
    assign rd_row   = RW'(grp_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign last     = (grp_reg + 4'd1 == total_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_lane[wr_lane][wr_row] <= op.data;
        end
        for (int l = 0; l < GROUP_BYTES; l++) begin
            rdata_reg[l] <= mem_lane[l][rd_row];
        end
    end

    always_comb begin
        priority if (rdata_reg[0] < cfg.finger_limit) begin
            kind = (rdata_reg[1] == POSITION_ACTION) ? KIND_POS : KIND_DRIVE;
        end else if (rdata_reg[1] == cfg.wrist_cw_code) begin
            kind = KIND_CW;
        end else if (rdata_reg[1] == cfg.wrist_acw_code) begin
            kind = KIND_ACW;
        end else begin
            kind = KIND_NOP;
        end
    end

    always_comb begin
        st_next    = st_reg;
        grp_next   = grp_reg;
        total_next = total_reg;
        load       = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                if (op_valid && op.commit) begin
                    total_next = op.data[3:0];
                    grp_next   = 4'd0;
                    st_next    = ST_READ;
                end
            end
            ST_READ: begin
                st_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    load     = 1'b1;
                    grp_next = grp_reg + 4'd1;
                    st_next  = last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            grp_reg     <= 4'd0;
            total_reg   <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            grp_reg     <= grp_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            id_reg   <= rdata_reg[0];
            act_reg  <= rdata_reg[1];
            val_reg  <= {rdata_reg[2], rdata_reg[3]};
            last_reg <= last;
        end
    end

    logic [2:0] kind_reg;
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= kind;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_target_id     = id_reg;
    assign m_command_kind  = kind_reg;
    assign m_direction     = act_reg;
    assign m_command_value = val_reg;
    assign m_last_command  = last_reg;

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_valid && op_ready) |-> (st_reg == ST_IDLE))
        else $error("op taken while emitting");

    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!m_valid_reg || m_ready))
        else $error("output overwritten");

    a_grp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_READ || st_reg == ST_LOAD) |-> (grp_reg < total_reg))
        else $error("group index past frame");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && last) |=> (st_reg == ST_IDLE))
        else $error("run continues after last command");

endmodule

### src/hand_command_frame_parser_unit.sv
// Top level of the hand command frame parser: config registers, parser, queue, engine.
// One received byte is taken per cycle while the op queue has room; stored payload
// bytes drain into the payload memory at one per cycle while the engine is idle. After
// a valid end byte the frame's commands (up to eight) leave one at a time: a single-row
// read of the payload memory, then the output register, which holds while m_ready is
// low; the parser keeps taking bytes until the queue fills behind a running frame.
module hand_command_frame_parser_unit import hcfp_pkg::*; #(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_target_id,
    output logic [2:0]  m_command_kind,
    output logic [7:0]  m_direction,
    output logic [15:0] m_command_value,
    output logic        m_last_command,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    hcfp_cfg_t cfg_reg, cfg_next;
    hcfp_op_t  push_op, pop_op;
    logic      q_push, q_full, q_pop, q_valid;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FINGER_LIMIT: cfg_next.finger_limit   = cfg_data;
                CFG_WRIST_CW:     cfg_next.wrist_cw_code  = cfg_data;
                CFG_WRIST_ACW:    cfg_next.wrist_acw_code = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.finger_limit   <= RST_FINGER_LIMIT;
            cfg_reg.wrist_cw_code  <= RST_WRIST_CW;
            cfg_reg.wrist_acw_code <= RST_WRIST_ACW;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hcfp_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (push_op)
    );

    hcfp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_op   (push_op),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_op    (pop_op)
    );

    hcfp_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .op_valid        (q_valid),
        .op              (pop_op),
        .op_ready        (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_target_id     (m_target_id),
        .m_command_kind  (m_command_kind),
        .m_direction     (m_direction),
        .m_command_value (m_command_value),
        .m_last_command  (m_last_command)
    );

endmodule
